@@ rtl/jacobi_five_point_stencil_unit_assert.svh @@
// Assertion macros used by the checker file of the stencil unit.
`ifndef JACOBI_FIVE_POINT_STENCIL_UNIT_ASSERT_SVH
`define JACOBI_FIVE_POINT_STENCIL_UNIT_ASSERT_SVH

// Concurrent assertion sampled on a clock and disabled while reset is low.
`define JFPS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on a clock, active during reset as well.
`define JFPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/jfps_pkg.sv @@
// Package with types, constants and helper functions of the stencil unit.
`default_nettype none

package jfps_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int DATA_W     = 32;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int GW_W       = 11;
    localparam int RU_W       = 12;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int S_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_W + ROW_W + COL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [GW_W-1:0]          width_t;
    typedef logic [RU_W-1:0]          rows_t;

    // Register index as decoded from the word address.
    typedef enum logic {
        REG_GRID_WIDTH   = 1'b0,
        REG_ROWS_UPDATED = 1'b1
    } reg_idx_t;

    // Write request into the line buffers.
    typedef struct packed {
        logic  en;
        col_t  addr;
        data_t older_data;
        data_t prev_data;
    } lb_wr_t;

    function automatic width_t clamp_width(input width_t w);
        width_t r;
        r = w;
        if (w < width_t'(3)) begin
            r = width_t'(3);
        end else if (w > width_t'(MAX_WIDTH)) begin
            r = width_t'(MAX_WIDTH);
        end
        return r;
    endfunction

    function automatic rows_t clamp_rows(input rows_t n);
        rows_t r;
        r = n;
        if (n < rows_t'(1)) begin
            r = rows_t'(1);
        end else if (n > rows_t'(MAX_ROWS - 2)) begin
            r = rows_t'(MAX_ROWS - 2);
        end
        return r;
    endfunction

    // Column position after a width change: past the end means start of next row.
    function automatic col_t eff_col(input col_t c, input width_t w);
        return ({1'b0, c} >= w) ? col_t'(0) : c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jfps_line_buffers.sv @@
// Two row buffers holding the two grid rows above the incoming word.
`default_nettype none

module jfps_line_buffers (
    input  wire logic            aclk,
    input  wire jfps_pkg::lb_wr_t wr,
    input  wire jfps_pkg::col_t  rd_addr,
    output jfps_pkg::data_t      up_value,
    output jfps_pkg::data_t      mid_value,
    output jfps_pkg::data_t      right_value
);
    import jfps_pkg::*;

    data_t older_mem [MAX_WIDTH];
    data_t prev_mem  [MAX_WIDTH];
    data_t up_reg;
    data_t mid_reg;
    data_t right_reg;
    col_t  rd_addr_right;

    assign rd_addr_right = rd_addr + col_t'(1);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            older_mem[wr.addr] <= wr.older_data;
            prev_mem[wr.addr]  <= wr.prev_data;
        end
        up_reg    <= older_mem[rd_addr];
        mid_reg   <= prev_mem[rd_addr];
        right_reg <= prev_mem[rd_addr_right];
    end

    assign up_value    = up_reg;
    assign mid_value   = mid_reg;
    assign right_value = right_reg;

endmodule

`default_nettype wire

@@ rtl/jacobi_five_point_stencil_unit.sv @@
// Top level of the streaming five-point Jacobi stencil unit.
// The input stream carries one grid word per transfer in row-major order: a top
// halo row, rows_updated interior rows and a bottom halo row, each grid_width
// words wide. For every interior point a result word leaves on the output stream
// when the word directly below that point is accepted; it carries the quarter
// sum of the four neighbors together with the point's row and column, and tlast
// marks the final result of a pass. Border columns and halo rows give no result.
// The result appears on m_tvalid in the cycle after the input word is accepted.
// One word is accepted each cycle unless the output stalls; the single result
// register accepts a new word whenever it is empty or being drained.
// A stalled receiver holds the result register and, while it is full, lowers s_tready.
// Line buffer reads are issued ahead from the next column position.
// Reset clears the position counters, the result valid flag and the registers
// to grid_width 1024 and rows_updated 1022. The line buffers are not cleared:
// every entry is written by the top halo row before it is read. The user must
// write grid_width and rows_updated at APB byte addresses 0 and 4 only while the
// stream is idle; the block does not enforce it. Out-of-range values are clamped.
`default_nettype none

module jacobi_five_point_stencil_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [jfps_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] sample
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [jfps_pkg::M_TDATA_W-1:0]        m_tdata,   // [31:0] new_value,
                                                             // [43:32] out_row,
                                                             // [53:44] out_col
    output logic                                  m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [jfps_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [jfps_pkg::PDATA_W-1:0]     pwdata,
    output logic [jfps_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);
    import jfps_pkg::*;

    width_t gw_reg, gw_next;
    rows_t  ru_reg, ru_next;
    col_t   col_reg, col_next;
    row_t   row_reg, row_next;
    data_t  left_reg, left_next;

    logic   mvalid_reg, mvalid_next;
    data_t  nv_reg;
    row_t   orow_reg;
    col_t   ocol_reg;
    logic   olast_reg;

    logic   cfg_wr;
    reg_idx_t cfg_idx;
    width_t w_eff;
    rows_t  rows_eff;
    width_t w_eff_next;

    logic   accept;
    logic   emit;
    col_t   c_eff;
    logic [ROW_W:0] r_tmp;
    row_t   r_eff;
    logic [ROW_W:0] rows_end;
    width_t c_plus1;
    logic [ROW_W:0] r_plus1;

    data_t  sample;
    data_t  up_value, mid_value, right_value;
    logic signed [DATA_W+1:0] sum4;
    data_t  nv;
    logic   last_hit;
    lb_wr_t lb_wr;
    col_t   rd_addr;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        gw_next = gw_reg;
        ru_next = ru_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GRID_WIDTH:   gw_next = pwdata[GW_W-1:0];
                REG_ROWS_UPDATED: ru_next = pwdata[RU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GRID_WIDTH:   prdata = PDATA_W'(gw_reg);
            REG_ROWS_UPDATED: prdata = PDATA_W'(ru_reg);
            default:          prdata = '0;
        endcase
    end

    assign w_eff      = clamp_width(gw_reg);
    assign rows_eff   = clamp_rows(ru_reg);
    assign w_eff_next = clamp_width(gw_next);

    // Current position, rewrapped in case the configuration changed.
    assign c_eff    = eff_col(col_reg, w_eff);
    assign r_tmp    = ({1'b0, col_reg} >= w_eff) ?
                      ({1'b0, row_reg} + (ROW_W+1)'(1)) : {1'b0, row_reg};
    assign rows_end = (ROW_W+1)'(rows_eff) + (ROW_W+1)'(2);
    assign r_eff    = (r_tmp >= rows_end) ? row_t'(0) : r_tmp[ROW_W-1:0];

    assign s_tready = !mvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = data_t'(s_tdata[DATA_W-1:0]);

    assign c_plus1 = width_t'({1'b0, c_eff}) + width_t'(1);
    assign r_plus1 = {1'b0, r_eff} + (ROW_W+1)'(1);

    assign emit = accept && (r_eff >= row_t'(2)) && (c_eff != col_t'(0)) && (c_plus1 < w_eff);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept) begin
            left_next = mid_value;
            if (c_plus1 >= w_eff) begin
                col_next = '0;
                row_next = (r_plus1 >= rows_end) ? row_t'(0) : r_plus1[ROW_W-1:0];
            end else begin
                col_next = c_plus1[COL_W-1:0];
                row_next = r_eff;
            end
        end
    end

    // Stencil arithmetic: floor of the quarter of the four-neighbor sum.
    assign sum4 = (DATA_W+2)'(up_value) + (DATA_W+2)'(sample)
                + (DATA_W+2)'(left_reg) + (DATA_W+2)'(right_value);
    assign nv   = data_t'(sum4[DATA_W+1:2]);

    assign last_hit = ({1'b0, r_eff} == ((ROW_W+1)'(rows_eff) + (ROW_W+1)'(1)))
                   && ((c_plus1 + width_t'(1)) == w_eff);

    assign mvalid_next = accept ? emit : (mvalid_reg && !m_tready);

    // Line buffers, read ahead at the next column.
    assign lb_wr.en         = accept;
    assign lb_wr.addr       = c_eff;
    assign lb_wr.older_data = mid_value;
    assign lb_wr.prev_data  = sample;
    assign rd_addr          = eff_col(col_next, w_eff_next);

    jfps_line_buffers u_line_buffers (
        .aclk        (aclk),
        .wr          (lb_wr),
        .rd_addr     (rd_addr),
        .up_value    (up_value),
        .mid_value   (mid_value),
        .right_value (right_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg     <= width_t'(1024);
            ru_reg     <= rows_t'(1022);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            gw_reg     <= gw_next;
            ru_reg     <= ru_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            nv_reg    <= nv;
            orow_reg  <= r_eff - row_t'(1);
            ocol_reg  <= c_eff;
            olast_reg <= last_hit;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = M_TDATA_W'({ocol_reg, orow_reg, nv_reg});
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

@@ rtl/jfps_checker.sv @@
// Port-level checker of the stencil unit and its bind to the top level.
`default_nettype none
`include "jacobi_five_point_stencil_unit_assert.svh"

module jfps_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [jfps_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);
    import jfps_pkg::*;

    `JFPS_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `JFPS_ASSERT_RST(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled word changed")
    `JFPS_ASSERT_RST(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")
    `JFPS_ASSERT_RST(a_result_needs_word, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready), "result without accepted word")
    `JFPS_ASSERT_RST(a_interior_column, aclk, aresetn, m_tvalid |-> m_tdata[M_FIELDS_W-1:DATA_W+ROW_W] != '0, "result in border column")

endmodule

bind jacobi_five_point_stencil_unit jfps_checker u_jfps_checker (.*);

`default_nettype wire
